FILE: rtl/iirdf2_pkg.sv
// Shared types, widths and constants for the direct form II IIR filter.
// Holds the control word layout, the step program and the rounding helpers.
// No dependencies.
package iirdf2_pkg;

    localparam int ORDER_DEF = 3;             // default filter order
    localparam int ORDER_MAX = 3;             // the program covers taps 1..3

    localparam int X_W    = 16;               // sample width, Q1.15
    localparam int Y_W    = 16;               // output width, Q1.15
    localparam int C_W    = 18;               // coefficient width, Q4.14
    localparam int W_W    = 24;               // intermediate width, Q9.15
    localparam int PROD_W = W_W + C_W;        // exact product, Q.29
    localparam int ACC_W  = PROD_W + 3;       // room for four products
    localparam int FRAC_SH = 14;              // Q.29 to Q.15
    localparam int RND_W  = ACC_W - FRAC_SH;
    localparam int RND_HALF = 8192;           // 2^13, rounds half up

    // configuration register indexes
    localparam int NUM_COEF = 7;
    localparam int IDX_W    = 3;
    localparam logic [IDX_W-1:0] REG_B0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_B3    = 3'd3;
    localparam logic [IDX_W-1:0] REG_A1    = 3'd4;
    localparam logic [IDX_W-1:0] REG_A2    = 3'd5;
    localparam logic [IDX_W-1:0] REG_A3    = 3'd6;
    localparam logic [IDX_W-1:0] REG_FB_EN = 3'd7;
    localparam logic signed [C_W-1:0] B0_RST = 18'sd16384;

    // datapath operations
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd0;
    localparam logic [OP_W-1:0] OP_ASUB = 2'd1;   // w acc -= a * tap
    localparam logic [OP_W-1:0] OP_BADD = 2'd2;   // y acc += b * tap

    localparam int TAP_W  = 2;                // tap 0 is the fresh w
    localparam int STEP_W = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  csel;   // coefficient register
        logic [TAP_W-1:0]  tap;
        logic              wsat;   // latch rounded, saturated w
        logic              last;
        logic              jmp;    // jump when feedback is off
        logic [STEP_W-1:0] tgt;
    } t_ctrl;

    function automatic t_ctrl f_prog(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '0;
        case (step)
            3'd0: begin
                c.op = OP_ASUB; c.csel = REG_A1; c.tap = 2'd1;
                c.jmp = 1'b1; c.tgt = 3'd3;
            end
            3'd1: begin c.op = OP_ASUB; c.csel = REG_A2; c.tap = 2'd2; end
            3'd2: begin c.op = OP_ASUB; c.csel = REG_A3; c.tap = 2'd3; end
            3'd3: begin
                c.op = OP_BADD; c.csel = REG_B1; c.tap = 2'd1; c.wsat = 1'b1;
            end
            3'd4: begin c.op = OP_BADD; c.csel = REG_B2; c.tap = 2'd2; end
            3'd5: begin c.op = OP_BADD; c.csel = REG_B3; c.tap = 2'd3; end
            3'd6: begin c.op = OP_BADD; c.csel = REG_B0; c.tap = 2'd0; end
            3'd7: begin c.op = OP_NOP; c.last = 1'b1; end
            default: c = '0;
        endcase
        return c;
    endfunction

    // (v + 2^13) floored over 2^14
    function automatic logic signed [RND_W-1:0] f_round(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(RND_HALF);
        return t[ACC_W-1:FRAC_SH];
    endfunction

    function automatic logic signed [W_W-1:0] f_sat_w(input logic signed [RND_W-1:0] v);
        if ((&v[RND_W-1:W_W-1]) || !(|v[RND_W-1:W_W-1]))
            return v[W_W-1:0];
        else if (v[RND_W-1])
            return {1'b1, {(W_W-1){1'b0}}};
        else
            return {1'b0, {(W_W-1){1'b1}}};
    endfunction

    function automatic logic signed [Y_W-1:0] f_sat_y(input logic signed [RND_W-1:0] v);
        if ((&v[RND_W-1:Y_W-1]) || !(|v[RND_W-1:Y_W-1]))
            return v[Y_W-1:0];
        else if (v[RND_W-1])
            return {1'b1, {(Y_W-1){1'b0}}};
        else
            return {1'b0, {(Y_W-1){1'b1}}};
    endfunction

endpackage

FILE: rtl/iirdf2_seq.sv
// Step sequencer for the IIR filter: step counter and program ROM.
// Depends on iirdf2_pkg (control word type and program).
module iirdf2_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_hold,
    input  logic                 i_fb_en,
    output iirdf2_pkg::t_ctrl    o_ctrl,
    output logic                 o_exec,
    output logic                 o_busy
);
    import iirdf2_pkg::*;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_ctrl             w_ctrl;
    logic              w_exec;

    assign w_ctrl = f_prog(r_step);
    // the final step waits while the previous result is still unclaimed
    assign w_exec = r_busy & ~(w_ctrl.last & i_hold);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (w_exec) begin
            if (w_ctrl.last)
                n_busy = 1'b0;
            else if (w_ctrl.jmp && !i_fb_en)
                n_step = w_ctrl.tgt;
            else
                n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_exec = w_exec;
    assign o_busy = r_busy;

endmodule

FILE: rtl/iir_direct_form_two_filter.sv
// Direct form II IIR filter: config registers, delay line and shared MAC datapath.
// Depends on iirdf2_pkg and iirdf2_seq.
//
// Usage:
//   Input channel i_valid/o_ready carries one Q1.15 sample and a clear_history
//   flag; the flag zeroes the delay line before that sample is filtered.
//   Output channel o_valid/i_ready returns one rounded, saturated Q1.15 sample
//   per input item, in order.
//   One 24x18 multiplier is shared by all taps under a stored step program:
//   three feedback taps then four feed-forward taps, one product per cycle.
//   Each item runs the stored steps in order (with feedback disabled the jump
//   skips the later feedback steps), and its result enters the output
//   register as its last step completes; the next item is taken in the cycle
//   the last step completes, not while an earlier item is still in progress.
//   A finished result waits in the output register; if it is still held when
//   the next item reaches its final step, that step stalls until i_ready.
//   Reset clears the delay line, sets b0 to 1.0, all other taps to zero and
//   enables feedback. Config writes (i_cfg_we) take effect at once and are
//   expected only while the block is idle.
module iir_direct_form_two_filter #(
    parameter int ORDER = iirdf2_pkg::ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [iirdf2_pkg::X_W-1:0]     i_sample_in,
    input  logic                                  i_clear_history,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [iirdf2_pkg::Y_W-1:0]     o_sample_out,
    input  logic                                  i_cfg_we,
    input  logic [iirdf2_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [iirdf2_pkg::C_W-1:0]            i_cfg_data
);
    import iirdf2_pkg::*;

    t_ctrl                    w_ctrl;
    logic                     w_exec, w_busy, w_fin, w_take, w_hold;
    logic signed [C_W-1:0]    r_coef [NUM_COEF];
    logic                     r_fb_en;
    logic signed [W_W-1:0]    r_dly [ORDER];
    logic signed [W_W-1:0]    r_w;
    logic signed [ACC_W-1:0]  r_acc_w, r_acc_y;
    logic signed [W_W-1:0]    w_mul_a;
    logic signed [C_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_x;
    logic                     r_out_valid;
    logic signed [Y_W-1:0]    r_out;

    iirdf2_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take),
        .i_hold  (w_hold),
        .i_fb_en (r_fb_en),
        .o_ctrl  (w_ctrl),
        .o_exec  (w_exec),
        .o_busy  (w_busy)
    );

    assign w_fin   = w_exec & w_ctrl.last;
    assign o_ready = ~w_busy | w_fin;
    assign w_take  = i_valid & o_ready;
    assign w_hold  = r_out_valid & ~i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++)
                r_coef[k] <= (IDX_W'(k) == REG_B0) ? B0_RST : '0;
            r_fb_en <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FB_EN)
                r_fb_en <= i_cfg_data[0];
            else
                r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // tap 0 is the new w; taps beyond ORDER read as zero
    always_comb begin
        w_mul_a = '0;
        if (w_ctrl.tap == '0)
            w_mul_a = r_w;
        for (int k = 0; k < ORDER; k++) begin
            if (w_ctrl.tap == TAP_W'(k + 1))
                w_mul_a = r_dly[k];
        end
    end

    assign w_mul_b  = r_coef[w_ctrl.csel];
    assign w_prod   = PROD_W'(w_mul_a * w_mul_b);
    assign w_prod_x = ACC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_acc_w <= {{(ACC_W-X_W-FRAC_SH){i_sample_in[X_W-1]}}, i_sample_in,
                        {FRAC_SH{1'b0}}};
            r_acc_y <= '0;
        end else if (w_exec) begin
            case (w_ctrl.op)
                // the first feedback step runs before its jump, so FIR mode skips it here
                OP_ASUB: begin
                    if (r_fb_en)
                        r_acc_w <= r_acc_w - w_prod_x;
                end
                OP_BADD: r_acc_y <= r_acc_y + w_prod_x;
                default: ;
            endcase
        end
        if (w_exec && w_ctrl.wsat)
            r_w <= f_sat_w(f_round(r_acc_w));
    end

    // history clear for a new item wins over the shift of the finishing one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ORDER; k++)
                r_dly[k] <= '0;
        end else if (w_take && i_clear_history) begin
            for (int k = 0; k < ORDER; k++)
                r_dly[k] <= '0;
        end else if (w_fin) begin
            for (int k = ORDER - 1; k > 0; k--)
                r_dly[k] <= r_dly[k-1];
            r_dly[0] <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_fin)
            r_out_valid <= 1'b1;
        else if (i_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_fin)
            r_out <= f_sat_y(f_round(r_acc_y));
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

endmodule
